@@ rtl/lru_keyed_slot_table_defines.svh @@
// assertion macros for the keyed slot table
// expects clk_i and rst_ni in the scope of each use
`ifndef LRU_KEYED_SLOT_TABLE_DEFINES_SVH
`define LRU_KEYED_SLOT_TABLE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define LKST_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define LKST_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lkst_pkg.sv @@
// shared types and constants for the keyed slot table
// no dependencies
package lkst_pkg;

  // parameter defaults
  localparam int SLOTS_DEF         = 2;
  localparam int FRAGMENTS_DEF     = 16;
  localparam int FRAGMENT_BITS_DEF = 64;

  // fixed field widths
  localparam int SERIAL_W   = 32;
  localparam int FREQ_W     = 30;
  localparam int FRAG_IDX_W = 8;
  localparam int WORD_W     = 64;
  localparam int TIME_W     = 32;
  localparam int ID_W       = 8;
  localparam int MASK_OUT_W = 16;
  localparam int STATUS_W   = 3;

  // item kind
  typedef enum logic {
    KIND_FRAME  = 1'b0,
    KIND_DELETE = 1'b1
  } kind_e;

  // result status
  typedef enum logic [STATUS_W-1:0] {
    ST_HIT         = 3'd0,
    ST_NEW         = 3'd1,
    ST_EVICT       = 3'd2,
    ST_DELETED     = 3'd3,
    ST_DEL_IGNORED = 3'd4
  } status_e;

  // input beat
  typedef struct packed {
    kind_e                 kind;
    logic [SERIAL_W-1:0]   serial_number;
    logic [FREQ_W-1:0]     freq_hz;
    logic [FRAG_IDX_W-1:0] fragment_index;
    logic [WORD_W-1:0]     fragment_word;
    logic [TIME_W-1:0]     time_now;
    logic [0:0]            delete_slot;
  } in_beat_t;

  // result beat
  typedef struct packed {
    logic [0:0]            slot_index;
    status_e               status;
    logic [ID_W-1:0]       entry_id;
    logic [MASK_OUT_W-1:0] fragment_mask;
  } out_beat_t;

endpackage

@@ rtl/lkst_chan_if.sv @@
// valid/ready channel carrying one beat of a given payload type
// payload types come from lkst_pkg
interface lkst_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/lru_keyed_slot_table.sv @@
// Keyed slot table with oldest-stamp replacement.
//
// Channels: in_i (sink) takes one beat per item, either a received frame
// keyed by serial number and frequency or a delete of one slot. out_o
// (source) gives exactly one result beat per item: slot, status, entry id
// and fragment mask. Both use valid/ready; a beat moves when both are high.
// Result path: an accepted beat is registered in the input stage, and its
// result is loaded into the output register when that stage fires (output
// register empty or out_o.ready high), which raises out_o.valid.
// Throughput: one item per cycle while out_o.ready is high. Lookup, free-slot search, oldest-stamp
// search and table update are a single combinational pass between the
// input stage and the output register; the table is written at the same
// edge, so a following item sees it at once.
// Stall: while out_o.ready is low with a result waiting, the input stage
// holds its item and in_i.ready drops once that stage is full.
// Reset: all slots free, entry id counter at zero, both stages empty.
// Fragment words are kept in an internal store of SLOTS*FRAGMENTS words.
// Depends on lkst_pkg, lkst_chan_if and lru_keyed_slot_table_defines.svh.
`include "lru_keyed_slot_table_defines.svh"

module lru_keyed_slot_table #(
  parameter int SLOTS         = lkst_pkg::SLOTS_DEF,
  parameter int FRAGMENTS     = lkst_pkg::FRAGMENTS_DEF,
  parameter int FRAGMENT_BITS = lkst_pkg::FRAGMENT_BITS_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  lkst_chan_if.sink   in_i,
  lkst_chan_if.source out_o
);

  localparam int SlotW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SlotCntW = SlotW + 1;
  localparam int FragIdxW = (FRAGMENTS > 1) ? $clog2(FRAGMENTS) : 1;
  localparam int MemDepth = SLOTS * FRAGMENTS;
  localparam int MemAw    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int MaskPadW = (FRAGMENTS > lkst_pkg::MASK_OUT_W) ? FRAGMENTS
                                                               : lkst_pkg::MASK_OUT_W;
  localparam logic [lkst_pkg::FRAG_IDX_W-1:0] FragLimit =
    lkst_pkg::FRAG_IDX_W'(FRAGMENTS);
  localparam logic [SlotCntW-1:0] SlotsLimit = SlotCntW'(SLOTS);

  // input stage
  logic               s1_vld_q;
  lkst_pkg::in_beat_t s1_q;
  logic               s1_fire;

  // table state
  logic [SLOTS-1:0]                  slot_valid_q;
  logic [lkst_pkg::SERIAL_W-1:0]     slot_serial_q [SLOTS];
  logic [lkst_pkg::FREQ_W-1:0]       slot_freq_q   [SLOTS];
  logic [lkst_pkg::TIME_W-1:0]       slot_stamp_q  [SLOTS];
  logic [lkst_pkg::ID_W-1:0]         slot_id_q     [SLOTS];
  logic [FRAGMENTS-1:0]              slot_mask_q   [SLOTS];
  logic [FRAGMENT_BITS-1:0]          frag_mem_q    [MemDepth];
  logic [lkst_pkg::ID_W-1:0]         id_cnt_q;

  // result register
  logic                res_vld_q;
  lkst_pkg::out_beat_t res_q;
  lkst_pkg::out_beat_t res_d;
  logic [SlotW-1:0]    res_slot_q;
  logic [SlotW-1:0]    res_slot_d;

  // lookup and allocation
  logic [SLOTS-1:0]              hit_vec;
  logic                          hit_any;
  logic [SlotW-1:0]              hit_idx;
  logic                          free_any;
  logic [SlotW-1:0]              free_idx;
  logic [SlotW-1:0]              ev_idx;
  logic [lkst_pkg::TIME_W-1:0]   ev_stamp;
  logic [SlotW-1:0]              slot_sel;
  lkst_pkg::status_e             frame_status;
  logic                          is_frame;
  logic                          alloc;
  logic                          alloc_fire;
  logic                          frag_ok;
  logic [FragIdxW-1:0]           frag_idx_lo;
  logic [FRAGMENTS-1:0]          frag_bit;
  logic [FRAGMENTS-1:0]          mask_new;
  logic [MaskPadW-1:0]           mask_pad;
  logic [lkst_pkg::ID_W-1:0]     id_new;
  logic [MemAw-1:0]              mem_addr;
  logic [SlotW-1:0]              del_idx;
  logic                          del_ok;

  // handshake
  assign s1_fire     = s1_vld_q && (!res_vld_q || out_o.ready);
  assign in_i.ready  = !s1_vld_q || s1_fire;
  assign out_o.valid = res_vld_q;
  assign out_o.payload = res_q;

  // input stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_vld_q <= in_i.valid;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_q <= in_i.payload;
    end
  end

  // key compare against every slot
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i] = slot_valid_q[i] && (slot_serial_q[i] == s1_q.serial_number) &&
                   (slot_freq_q[i] == s1_q.freq_hz);
    end
  end

  // lowest hit and lowest free slot
  always_comb begin
    hit_any  = |hit_vec;
    free_any = !(&slot_valid_q);
    hit_idx  = '0;
    free_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_idx = SlotW'(i);
      end
      if (!slot_valid_q[i]) begin
        free_idx = SlotW'(i);
      end
    end
  end

  // oldest stamp, ties to the lowest slot
  always_comb begin
    ev_idx   = '0;
    ev_stamp = slot_stamp_q[0];
    for (int i = 1; i < SLOTS; i++) begin
      if (slot_stamp_q[i] < ev_stamp) begin
        ev_stamp = slot_stamp_q[i];
        ev_idx   = SlotW'(i);
      end
    end
  end

  // slot choice and new slot contents
  always_comb begin
    if (hit_any) begin
      slot_sel     = hit_idx;
      frame_status = lkst_pkg::ST_HIT;
    end else if (free_any) begin
      slot_sel     = free_idx;
      frame_status = lkst_pkg::ST_NEW;
    end else begin
      slot_sel     = ev_idx;
      frame_status = lkst_pkg::ST_EVICT;
    end
    is_frame    = (s1_q.kind == lkst_pkg::KIND_FRAME);
    alloc       = !hit_any;
    alloc_fire  = s1_fire && is_frame && alloc;
    frag_ok     = (s1_q.fragment_index < FragLimit);
    frag_idx_lo = s1_q.fragment_index[FragIdxW-1:0];
    frag_bit    = frag_ok ? (FRAGMENTS'(1) << frag_idx_lo) : '0;
    mask_new    = (alloc ? '0 : slot_mask_q[slot_sel]) | frag_bit;
    mask_pad    = MaskPadW'(mask_new);
    id_new      = alloc ? id_cnt_q : slot_id_q[slot_sel];
    mem_addr    = MemAw'(MemAw'(slot_sel) * MemAw'(FRAGMENTS) + MemAw'(frag_idx_lo));
  end

  // delete check
  always_comb begin
    del_idx = SlotW'(s1_q.delete_slot);
    del_ok  = (SlotCntW'(s1_q.delete_slot) < SlotsLimit) && slot_valid_q[del_idx];
  end

  // result beat
  always_comb begin
    if (is_frame) begin
      res_slot_d          = slot_sel;
      res_d.slot_index    = slot_sel[0];
      res_d.status        = frame_status;
      res_d.entry_id      = id_new;
      res_d.fragment_mask = mask_pad[lkst_pkg::MASK_OUT_W-1:0];
    end else begin
      res_slot_d          = del_idx;
      res_d.slot_index    = s1_q.delete_slot;
      res_d.status        = del_ok ? lkst_pkg::ST_DELETED : lkst_pkg::ST_DEL_IGNORED;
      res_d.entry_id      = '0;
      res_d.fragment_mask = '0;
    end
  end

  // valid bits and id counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      id_cnt_q     <= '0;
    end else if (s1_fire) begin
      if (is_frame) begin
        if (alloc) begin
          slot_valid_q[slot_sel] <= 1'b1;
          id_cnt_q               <= id_cnt_q + lkst_pkg::ID_W'(1);
        end
      end else if (del_ok) begin
        slot_valid_q[del_idx] <= 1'b0;
      end
    end
  end

  // slot contents
  always_ff @(posedge clk_i) begin
    if (s1_fire && is_frame) begin
      if (alloc) begin
        slot_serial_q[slot_sel] <= s1_q.serial_number;
        slot_freq_q[slot_sel]   <= s1_q.freq_hz;
        slot_id_q[slot_sel]     <= id_cnt_q;
      end
      slot_mask_q[slot_sel]  <= mask_new;
      slot_stamp_q[slot_sel] <= s1_q.time_now;
    end
  end

  // fragment word store
  always_ff @(posedge clk_i) begin
    if (s1_fire && is_frame && frag_ok) begin
      frag_mem_q[mem_addr] <= s1_q.fragment_word[FRAGMENT_BITS-1:0];
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (!res_vld_q || out_o.ready) begin
      res_vld_q <= s1_vld_q;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      res_q      <= res_d;
      res_slot_q <= res_slot_d;
    end
  end

  // a slot that was used is valid while its result waits
  `LKST_ASSERT_IMP(a_used_slot_valid, res_vld_q && (res_q.status == lkst_pkg::ST_HIT || res_q.status == lkst_pkg::ST_NEW || res_q.status == lkst_pkg::ST_EVICT), slot_valid_q[res_slot_q], "used slot not valid")
  // a deleted slot is free while its result waits
  `LKST_ASSERT_IMP(a_deleted_slot_free, res_vld_q && res_q.status == lkst_pkg::ST_DELETED, !slot_valid_q[res_slot_q], "deleted slot still valid")
  // eviction only happens with a full table
  `LKST_ASSERT_IMP(a_evict_full, res_vld_q && res_q.status == lkst_pkg::ST_EVICT, &slot_valid_q, "eviction with a free slot")
  // id counter steps once per allocation
  `LKST_ASSERT_NXT(a_id_step, alloc_fire, id_cnt_q == $past(id_cnt_q) + 8'd1, "id counter did not step")
  // id counter holds otherwise
  `LKST_ASSERT_NXT(a_id_hold, !alloc_fire, $stable(id_cnt_q), "id counter moved without allocation")

endmodule
